>>> hw/rtl/rcet_pkg.sv
package rcet_pkg;

	localparam int CYC_W  = 32;
	localparam int VAL_W  = 16;
	localparam int RATE_W = 20;
	localparam int IRQ_W  = 7;
	localparam int NEXT_W = 31;
	localparam int NCTR   = 4;

	localparam logic [2:0] ACT_CHECK = 3'd0;
	localparam logic [2:0] ACT_WCNT  = 3'd1;
	localparam logic [2:0] ACT_WMODE = 3'd2;
	localparam logic [2:0] ACT_WTGT  = 3'd3;
	localparam logic [2:0] ACT_READ  = 3'd4;
	localparam logic [2:0] ACT_NOP   = 3'd5;

	localparam logic [2:0] RS_ONE   = 3'd0;
	localparam logic [2:0] RS_DIV0  = 3'd1;
	localparam logic [2:0] RS_DIV1  = 3'd2;
	localparam logic [2:0] RS_EIGHT = 3'd3;
	localparam logic [2:0] RS_KEEP  = 3'd4;

	localparam logic [1:0] VSYNC_CTR = 2'd3;
	localparam logic [1:0] CTR2      = 2'd2;
	localparam logic [1:0] CTR1      = 2'd1;
	localparam logic [1:0] CTR0      = 2'd0;

	localparam logic [CYC_W-1:0]  DISARMED   = 32'hffff_ffff;
	localparam logic [NEXT_W-1:0] NEXT_NONE  = 31'h7fff_ffff;
	localparam logic [VAL_W-1:0]  CNT_TOP    = 16'hffff;
	localparam logic [RATE_W-1:0] VSYNC_RST  = 20'd564480;
	localparam logic [VAL_W-1:0]  MODE3_RST  = 16'h0058;
	localparam logic [VAL_W-1:0]  TGT3_RST   = 16'h0001;
	localparam logic [RATE_W-1:0] DIV_DOT0   = 20'd101132; // 386 * 262
	localparam logic [RATE_W-1:0] DIV_LINE1  = 20'd262;
	localparam logic [9:0]        SEL_CLK1   = 10'h100;
	localparam logic [9:0]        SEL_CLK2   = 10'h200;

	typedef struct packed {
		logic [2:0]       action;
		logic [1:0]       counter_index;
		logic [VAL_W-1:0] write_value;
		logic [CYC_W-1:0] cpu_cycle;
	} in_t;

	typedef struct packed {
		logic [VAL_W-1:0]  read_data;
		logic [IRQ_W-1:0]  irq_set;
		logic [NEXT_W-1:0] next_event;
		logic [CYC_W-1:0]  next_base;
	} out_t;

	typedef struct packed {
		logic [2:0]       kind;
		logic [2:0]       rsel;
		logic [1:0]       idx;
		logic [VAL_W-1:0] val;
		logic [CYC_W-1:0] now;
	} cmd_t;

	function automatic logic [IRQ_W-1:0] irq_bit(input logic [1:0] i);
		logic [IRQ_W-1:0] b;
		case (i)
			CTR0:    b = 7'h10;
			CTR1:    b = 7'h20;
			CTR2:    b = 7'h40;
			default: b = 7'h01;
		endcase
		return b;
	endfunction

endpackage

>>> hw/rtl/root_counter_event_timer.sv
// channel   signals                      transfer when
// input     push, full, item             push & !full
// result    pop, empty, result           pop & !empty
// config    cfg_we, cfg_data             cfg_we
//
// One item at a time in the back end. Read count and a mode write that
// derives a rate run the serial divider; the other actions do not.
// Reset restores all counter state at once; no sweep.
// Input and result queues let either side stall without stopping the other.
module root_counter_event_timer import rcet_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  in_t               item,
	input  logic              pop,
	output logic              empty,
	output out_t              result,
	input  logic              cfg_we,
	input  logic [RATE_W-1:0] cfg_data
);

	cmd_t cmd;
	out_t res;
	logic cmd_valid, cmd_pop, res_full, res_push;

	rcet_front #(.DEPTH(QUEUE_DEPTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.cmd_pop  (cmd_pop),
		.cmd_valid(cmd_valid),
		.cmd      (cmd)
	);

	rcet_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res)
	);

	rcet_fifo #(.W($bits(out_t)), .DEPTH(QUEUE_DEPTH)) u_res (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (res_push),
		.wdata (res),
		.rd    (pop),
		.rdata (result),
		.full  (res_full),
		.empty (empty)
	);

endmodule

>>> hw/rtl/rcet_fifo.sv
module rcet_fifo import rcet_pkg::*; #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	input  logic         rd,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         empty
);

	localparam int AW = $clog2(DEPTH);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          do_wr, do_rd;

	assign full  = cnt_q == (AW+1)'(DEPTH);
	assign empty = cnt_q == '0;
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(do_wr) - (AW+1)'(do_rd);
		end
	end

endmodule

>>> hw/rtl/rcet_div.sv
module rcet_div import rcet_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [CYC_W-1:0]  num,
	input  logic [RATE_W-1:0] den,
	output logic              done,
	output logic [CYC_W-1:0]  quo
);

	localparam int SW = $clog2(CYC_W);

	logic [CYC_W-1:0]  n_q;
	logic [RATE_W-1:0] r_q, d_q;
	logic [SW-1:0]     step_q;
	logic              busy_q, done_q;
	logic [RATE_W:0]   sh;
	logic              ge;

	// restoring, one quotient bit per cycle; zero divisor gives all ones
	assign sh   = {r_q, n_q[CYC_W-1]};
	assign ge   = sh >= {1'b0, d_q};
	assign done = done_q;
	assign quo  = n_q;

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			r_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[CYC_W-2:0], ge};
			r_q <= ge ? RATE_W'(sh - {1'b0, d_q}) : sh[RATE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= !start && busy_q && step_q == '0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= SW'(CYC_W-1);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

>>> hw/rtl/rcet_front.sv
module rcet_front import rcet_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  in_t  item,
	output logic full,
	input  logic cmd_pop,
	output logic cmd_valid,
	output cmd_t cmd
);

	cmd_t cls;
	logic empty;

	always_comb begin
		cls.idx  = item.counter_index;
		cls.val  = item.write_value;
		cls.now  = item.cpu_cycle;
		cls.rsel = RS_KEEP;
		case (item.action)
			ACT_CHECK: cls.kind = ACT_CHECK;
			ACT_WCNT:  cls.kind = ACT_WCNT;
			ACT_WMODE: cls.kind = ACT_WMODE;
			ACT_WTGT:  cls.kind = ACT_WTGT;
			ACT_READ:  cls.kind = ACT_READ;
			default:   cls.kind = ACT_NOP;
		endcase
		case (item.counter_index)
			CTR0: cls.rsel = (item.write_value[9:0] & 10'h300) == SEL_CLK1 ? RS_DIV0 : RS_ONE;
			CTR1: cls.rsel = (item.write_value[9:0] & 10'h300) == SEL_CLK1 ? RS_DIV1 : RS_ONE;
			CTR2: cls.rsel = (item.write_value[9:0] & 10'h300) == SEL_CLK2 ? RS_EIGHT : RS_ONE;
			default: cls.rsel = RS_KEEP;
		endcase
	end

	rcet_fifo #(.W($bits(cmd_t)), .DEPTH(DEPTH)) u_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (push),
		.wdata (cls),
		.rd    (cmd_pop),
		.rdata (cmd),
		.full  (full),
		.empty (empty)
	);

	assign cmd_valid = !empty;

endmodule

>>> hw/rtl/rcet_back.sv
module rcet_back import rcet_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [RATE_W-1:0] cfg_data,
	input  logic              cmd_valid,
	input  cmd_t              cmd,
	output logic              cmd_pop,
	input  logic              res_full,
	output logic              res_push,
	output out_t              res
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CHK  = 3'd1;
	localparam logic [2:0] S_RS   = 3'd2;
	localparam logic [2:0] S_DIVS = 3'd3;
	localparam logic [2:0] S_DIVW = 3'd4;
	localparam logic [2:0] S_NX   = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	logic [2:0]        st_q;
	logic [1:0]        cur_q;
	cmd_t              cmd_q;
	logic [VAL_W-1:0]  rd_q;
	logic [IRQ_W-1:0]  irq_q;
	logic              neg_q, dis_q;
	logic [NEXT_W-1:0] min_q;

	logic [VAL_W-1:0]  cnt_q   [NCTR];
	logic [VAL_W-1:0]  mode_q  [NCTR];
	logic [VAL_W-1:0]  tgt_q   [NCTR];
	logic [RATE_W-1:0] rate_q  [NCTR];
	logic [CYC_W-1:0]  start_q [NCTR];
	logic [CYC_W-1:0]  dly_q   [NCTR];

	logic [CYC_W-1:0]  elapsed, span, prod, left, div_num, quo;
	logic [RATE_W-1:0] div_den;
	logic [VAL_W-1:0]  m;
	logic              due, armed, div_start, div_done;

	assign m       = mode_q[cur_q];
	assign elapsed = cmd_q.now - start_q[cur_q];
	assign due     = dly_q[cur_q] != DISARMED && elapsed >= dly_q[cur_q];
	assign armed   = (!m[0] || cur_q != CTR2) && (m[4] || m[5]);
	assign span    = m[4] ? CYC_W'(tgt_q[cur_q]) - CYC_W'(cnt_q[cur_q])
	                      : CYC_W'(CNT_TOP) - CYC_W'(cnt_q[cur_q]);
	assign prod    = span * CYC_W'(rate_q[cur_q]);
	assign left    = dly_q[cur_q] - elapsed;

	always_comb begin
		if (cmd_q.kind == ACT_READ) begin
			div_num = m[3] ? elapsed : cmd_q.now;
			div_den = rate_q[cur_q];
		end else begin
			div_num = CYC_W'(rate_q[VSYNC_CTR]);
			div_den = (cmd_q.rsel == RS_DIV0) ? DIV_DOT0 : DIV_LINE1;
		end
	end

	assign div_start = st_q == S_DIVS;
	assign cmd_pop   = st_q == S_IDLE && cmd_valid && !res_full;
	assign res_push  = st_q == S_FIN;

	assign res.read_data  = rd_q;
	assign res.irq_set    = irq_q;
	assign res.next_event = neg_q ? '0 : min_q;
	assign res.next_base  = cmd_q.now;

	rcet_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (quo)
	);

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= S_IDLE;
			cur_q <= '0;
			rd_q  <= '0;
			irq_q <= '0;
			neg_q <= 1'b0;
			dis_q <= 1'b0;
			min_q <= NEXT_NONE;
			for (int i = 0; i < NCTR; i++) begin
				cnt_q[i]   <= '0;
				mode_q[i]  <= '0;
				tgt_q[i]   <= '0;
				rate_q[i]  <= RATE_W'(1);
				start_q[i] <= '0;
				dly_q[i]   <= DISARMED;
			end
			mode_q[VSYNC_CTR] <= MODE3_RST;
			tgt_q[VSYNC_CTR]  <= TGT3_RST;
			rate_q[VSYNC_CTR] <= VSYNC_RST;
			dly_q[VSYNC_CTR]  <= CYC_W'(VSYNC_RST >> 1);
		end else begin
			if (cfg_we) begin
				rate_q[VSYNC_CTR] <= cfg_data;
			end
			case (st_q)
				S_IDLE: begin
					if (cmd_pop) begin
						rd_q  <= '0;
						irq_q <= '0;
						neg_q <= 1'b0;
						dis_q <= 1'b0;
						min_q <= NEXT_NONE;
						case (cmd.kind)
							ACT_CHECK: begin
								cur_q <= '0;
								st_q  <= S_CHK;
							end
							ACT_WCNT: begin
								cur_q <= cmd.idx;
								cnt_q[cmd.idx] <= cmd.val;
								st_q <= S_RS;
							end
							ACT_WMODE: begin
								cur_q <= cmd.idx;
								mode_q[cmd.idx] <= cmd.val;
								cnt_q[cmd.idx]  <= '0;
								case (cmd.rsel)
									RS_ONE: begin
										rate_q[cmd.idx] <= RATE_W'(1);
										st_q <= S_RS;
									end
									RS_EIGHT: begin
										rate_q[cmd.idx] <= RATE_W'(8);
										st_q <= S_RS;
									end
									RS_DIV0, RS_DIV1: st_q <= S_DIVS;
									default: st_q <= S_RS;
								endcase
							end
							ACT_WTGT: begin
								cur_q <= cmd.idx;
								tgt_q[cmd.idx] <= cmd.val;
								st_q <= S_RS;
							end
							ACT_READ: begin
								cur_q <= cmd.idx;
								st_q  <= S_DIVS;
							end
							default: begin
								cur_q <= '0;
								st_q  <= S_NX;
							end
						endcase
					end
				end
				S_CHK: begin
					if (due) begin
						irq_q <= irq_q | irq_bit(cur_q);
						if (cur_q != VSYNC_CTR) begin
							cnt_q[cur_q] <= '0;
						end
						dis_q <= cur_q != VSYNC_CTR && !m[6];
						st_q  <= S_RS;
					end else if (cur_q == VSYNC_CTR) begin
						cur_q <= '0;
						st_q  <= S_NX;
					end else begin
						cur_q <= cur_q + 1'b1;
					end
				end
				S_RS: begin
					start_q[cur_q] <= cmd_q.now;
					dly_q[cur_q]   <= (armed && !dis_q) ? {1'b0, prod[CYC_W-1:1]} : DISARMED;
					dis_q <= 1'b0;
					if (cmd_q.kind == ACT_CHECK && cur_q != VSYNC_CTR) begin
						cur_q <= cur_q + 1'b1;
						st_q  <= S_CHK;
					end else begin
						cur_q <= '0;
						st_q  <= S_NX;
					end
				end
				S_DIVS: st_q <= S_DIVW;
				S_DIVW: begin
					if (div_done) begin
						if (cmd_q.kind == ACT_READ) begin
							rd_q  <= cnt_q[cur_q] + {quo[VAL_W-2:0], 1'b0};
							cur_q <= '0;
							st_q  <= S_NX;
						end else begin
							rate_q[cur_q] <= quo[RATE_W-1:0];
							st_q <= S_RS;
						end
					end
				end
				S_NX: begin
					if (dly_q[cur_q] != DISARMED) begin
						if (left[CYC_W-1]) begin
							neg_q <= 1'b1;
						end else if (left[NEXT_W-1:0] < min_q) begin
							min_q <= left[NEXT_W-1:0];
						end
					end
					if (cur_q == VSYNC_CTR) begin
						st_q <= S_FIN;
					end else begin
						cur_q <= cur_q + 1'b1;
					end
				end
				S_FIN: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> hw/rtl/rcet_chk.sv
module rcet_chk import rcet_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic pop,
	input  logic empty,
	input  logic full,
	input  out_t result
);

	a_irq_bits: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> result.irq_set[3:1] == '0)
		else $error("reserved irq bits raised");

	a_read_or_check: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.read_data != '0 |-> result.irq_set == '0)
		else $error("read data and irq in one result");

	a_reset_empty: assert property (@(posedge clk)
		arst_n && !$past(arst_n) |-> empty && !full)
		else $error("queues not empty after reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("waiting result lost");

endmodule

bind root_counter_event_timer rcet_chk u_rcet_chk (
	.clk   (clk),
	.arst_n(arst_n),
	.pop   (pop),
	.empty (empty),
	.full  (full),
	.result(result)
);

>>> test/tb_root_counter_event_timer.sv
module tb_root_counter_event_timer;
	import rcet_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              push;
	logic              full;
	in_t               item;
	logic              pop;
	logic              empty;
	out_t              result;
	logic              cfg_we;
	logic [RATE_W-1:0] cfg_data;

	root_counter_event_timer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.pop      (pop),
		.empty    (empty),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	localparam int CYCLE_LIMIT = 1000000;

	// timer model state
	logic [31:0] vsync_step;
	logic [31:0] tmr_count [NCTR];
	logic [31:0] tmr_mode  [NCTR];
	logic [31:0] tmr_target[NCTR];
	logic [31:0] tmr_rate  [NCTR];
	logic [31:0] tmr_start [NCTR];
	logic [31:0] tmr_delay [NCTR];

	in_t  pending_accesses[$];
	out_t expected_reports[$];
	int   errors;
	int   accepted;
	int   checked;
	int   irq_seen;
	int   cycles;
	bit   gaps_on;
	logic [31:0] cpu_now;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [31:0] udiv(input logic [31:0] a, input logic [31:0] b);
		return (b == 0) ? 32'hffff_ffff : a / b;
	endfunction

	task automatic schedule(input int i, input logic [31:0] now);
		logic [31:0] m;
		logic [31:0] span;
		logic [31:0] prod;
		m = tmr_mode[i];
		tmr_start[i] = now;
		if ((!m[0] || i != 2) && (m[5:4] != 0)) begin
			span = m[4] ? (tmr_target[i] - tmr_count[i]) : (32'hffff - tmr_count[i]);
			prod = span * tmr_rate[i];
			tmr_delay[i] = prod >> 1;
		end else begin
			tmr_delay[i] = DISARMED;
		end
	endtask

	function automatic bit fired(input int i, input logic [31:0] now);
		return tmr_delay[i] != DISARMED && (now - tmr_start[i]) >= tmr_delay[i];
	endfunction

	task automatic timers_reset();
		vsync_step = VSYNC_RST;
		for (int i = 0; i < NCTR; i++) begin
			tmr_count[i]  = 0;
			tmr_mode[i]   = 0;
			tmr_target[i] = 0;
			tmr_rate[i]   = 1;
		end
		tmr_mode[3]   = MODE3_RST;
		tmr_target[3] = TGT3_RST;
		tmr_rate[3]   = vsync_step;
		for (int i = 0; i < NCTR; i++)
			schedule(i, 0);
	endtask

	task automatic timer_access(input in_t a, output out_t r);
		int          ix;
		logic [31:0] now;
		logic [31:0] rd;
		logic [31:0] irq;
		logic [31:0] nxt;
		logic [31:0] q;
		logic [31:0] left;
		logic [9:0]  sel;
		bit          stop;
		ix   = a.counter_index;
		now  = a.cpu_cycle;
		rd   = 0;
		irq  = 0;
		nxt  = 32'h7fff_ffff;
		stop = 0;
		case (a.action)
			ACT_CHECK: begin
				if (fired(3, now)) begin
					schedule(3, now);
					irq |= irq_bit(VSYNC_CTR);
				end
				for (int i = 0; i < 3; i++) begin
					if (fired(i, now)) begin
						tmr_count[i] = 0;
						schedule(i, now);
						irq |= irq_bit(i[1:0]);
						if (!tmr_mode[i][6])
							tmr_delay[i] = DISARMED;
					end
				end
			end
			ACT_WCNT: begin
				tmr_count[ix] = a.write_value;
				schedule(ix, now);
			end
			ACT_WMODE: begin
				sel = {a.write_value[9:8], 8'h00};
				tmr_mode[ix]  = a.write_value;
				tmr_count[ix] = 0;
				if (ix == 0)
					tmr_rate[0] = (sel == SEL_CLK1) ? (tmr_rate[3] / 386) / 262 : 1;
				else if (ix == 1)
					tmr_rate[1] = (sel == SEL_CLK1) ? tmr_rate[3] / 262 : 1;
				else if (ix == 2)
					tmr_rate[2] = (sel == SEL_CLK2) ? 8 : 1;
				schedule(ix, now);
			end
			ACT_WTGT: begin
				tmr_target[ix] = a.write_value;
				schedule(ix, now);
			end
			ACT_READ: begin
				if (tmr_mode[ix][3])
					q = udiv(now - tmr_start[ix], tmr_rate[ix]);
				else
					q = udiv(now, tmr_rate[ix]);
				rd = (tmr_count[ix] + 2 * q) & 32'hffff;
			end
			default: ;
		endcase
		for (int i = 0; i < NCTR; i++) begin
			if (!stop && tmr_delay[i] != DISARMED) begin
				left = tmr_delay[i] - (now - tmr_start[i]);
				if (left[31]) begin
					nxt  = 0;
					stop = 1;
				end else if (left < nxt) begin
					nxt = left;
				end
			end
		end
		r.read_data  = rd[VAL_W-1:0];
		r.irq_set    = irq[IRQ_W-1:0];
		r.next_event = nxt[NEXT_W-1:0];
		r.next_base  = now;
	endtask

	task automatic queue_access(input logic [2:0] act, input logic [1:0] ix,
			input logic [15:0] v, input logic [31:0] cyc);
		in_t a;
		a.action        = act;
		a.counter_index = ix;
		a.write_value   = v;
		a.cpu_cycle     = cyc;
		pending_accesses.push_back(a);
	endtask

	// random mix of checks, timer programming, reads and unused actions on a mostly advancing cycle count
	task automatic queue_random(input int n);
		logic [2:0]  act;
		logic [15:0] v;
		int          pick;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			if (pick < 38)      act = ACT_CHECK;
			else if (pick < 50) act = ACT_WCNT;
			else if (pick < 66) act = ACT_WMODE;
			else if (pick < 78) act = ACT_WTGT;
			else if (pick < 95) act = ACT_READ;
			else                act = 3'($urandom_range(ACT_NOP, 7));
			pick = $urandom_range(9);
			if (pick < 2)
				v = 16'($urandom);
			else if (act == ACT_WMODE)
				v = {6'($urandom_range(1) ? 0 : $urandom), 2'($urandom),
					1'b0, 3'($urandom_range(1) ? 3'b011 : $urandom), 4'($urandom)};
			else
				v = 16'($urandom_range(400));
			pick = $urandom_range(99);
			if (pick < 3)
				cpu_now = $urandom;
			else if (pick < 10)
				cpu_now += $urandom_range(2000000);
			else
				cpu_now += $urandom_range(600);
			queue_access(act, 2'($urandom), v, cpu_now);
		end
	endtask

	task automatic set_vsync(input logic [RATE_W-1:0] v);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we     <= 1'b0;
		vsync_step = v;
		tmr_rate[3] = v;
	endtask

	task automatic drain();
		while (pending_accesses.size() != 0 || push || expected_reports.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// sender
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				out_t r;
				timer_access(item, r);
				expected_reports.push_back(r);
				accepted++;
			end
			if (!push || !full) begin
				if (pending_accesses.size() != 0 && !(gaps_on && $urandom_range(99) < 15)) begin
					push <= 1'b1;
					item <= pending_accesses.pop_front();
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// receiver
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				out_t e;
				if (expected_reports.size() == 0) begin
					$display("%0t: unexpected result %h", $realtime, result);
					errors++;
				end else begin
					e = expected_reports.pop_front();
					checked++;
					if (e.irq_set != 0)
						irq_seen++;
					if (result.read_data !== e.read_data) begin
						$display("%0t: read_data exp %h got %h", $realtime,
							e.read_data, result.read_data);
						errors++;
					end
					if (result.irq_set !== e.irq_set) begin
						$display("%0t: irq_set exp %h got %h", $realtime,
							e.irq_set, result.irq_set);
						errors++;
					end
					if (result.next_event !== e.next_event) begin
						$display("%0t: next_event exp %h got %h", $realtime,
							e.next_event, result.next_event);
						errors++;
					end
					if (result.next_base !== e.next_base) begin
						$display("%0t: next_base exp %h got %h", $realtime,
							e.next_base, result.next_base);
						errors++;
					end
				end
			end
			pop <= !(gaps_on && $urandom_range(99) < 15);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		arst_n   = 1'b0;
		push     = 1'b0;
		pop      = 1'b0;
		item     = '0;
		cfg_we   = 1'b0;
		cfg_data = '0;
		errors   = 0;
		accepted = 0;
		checked  = 0;
		irq_seen = 0;
		cycles   = 0;
		gaps_on  = 1'b1;
		cpu_now  = 0;
		timers_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset vsync, rate selects, one-shot and repeat, extremes
		queue_access(ACT_CHECK, 0, 0, 32'd282240);
		queue_access(ACT_READ,  3, 0, 32'd1000000);
		queue_access(ACT_WMODE, 0, 16'h0150, 32'd1000010);
		queue_access(ACT_WMODE, 1, 16'h0178, 32'd1000020);
		queue_access(ACT_WMODE, 2, 16'h0258, 32'd1000030);
		queue_access(ACT_WTGT,  2, 16'd5, 32'd1000040);
		queue_access(ACT_WMODE, 2, 16'h0011, 32'd1000050);
		queue_access(ACT_WMODE, 2, 16'h0310, 32'd1000060);
		queue_access(ACT_WTGT,  2, 16'd3, 32'd1000070);
		queue_access(ACT_CHECK, 0, 0, 32'd1000072);
		queue_access(ACT_CHECK, 0, 0, 32'd1000090);
		queue_access(ACT_WCNT,  0, 16'hffff, 32'd1000100);
		queue_access(ACT_WCNT,  1, 16'h0000, 32'd1000110);
		queue_access(ACT_READ,  2, 0, 32'hffff_ffff);
		queue_access(ACT_READ,  0, 0, 32'd1000200);
		queue_access(ACT_READ,  1, 0, 32'd1000300);
		queue_access(ACT_CHECK, 0, 0, 32'hffff_fff0);
		queue_access(ACT_NOP,   3, 16'hffff, 32'd5);
		queue_access(3'd7,      1, 16'hffff, 32'd6);
		queue_access(ACT_WTGT,  3, 16'hffff, 32'd7);
		queue_access(ACT_CHECK, 0, 0, 32'd0);
		drain();

		// tiny vsync rate: derived rates become zero
		set_vsync(1);
		queue_access(ACT_WMODE, 0, 16'h0108, 32'd100);
		queue_access(ACT_WMODE, 1, 16'h0100, 32'd200);
		queue_access(ACT_READ,  0, 0, 32'd300);
		queue_access(ACT_READ,  1, 0, 32'd400);
		queue_access(ACT_WCNT,  3, 16'd0, 32'd500);
		queue_access(ACT_CHECK, 0, 0, 32'd501);
		cpu_now = 1000;
		queue_random(430);
		drain();

		set_vsync(20'hfffff);
		gaps_on = 1'b0;
		queue_random(450);
		drain();

		gaps_on = 1'b1;
		set_vsync(20'd2000);
		queue_random(450);
		drain();

		set_vsync(20'($urandom_range(1, 20'hfffff)));
		queue_random(450);
		drain();

		$display("%0d accesses, %0d results checked, %0d with interrupts raised",
			accepted, checked, irq_seen);
		$display("vsync rates 1, max, 2000, reset and random; rate selects and one-shot");
		if (errors == 0 && expected_reports.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
